// File: rtl/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int unsigned PosWidthDefault = 16;
  localparam int unsigned OutPosWidth     = 16;
  localparam int unsigned FifoDepth       = 2;

  localparam logic [2:0] PacketLenReset = 3'd3;
  localparam logic [2:0] PacketLenWheel = 3'd4;

  // Bit positions inside the first (flags) byte of a packet; WheelSign is in the wheel byte.
  localparam int unsigned FlagSync   = 3;
  localparam int unsigned FlagXSign  = 4;
  localparam int unsigned FlagYSign  = 5;
  localparam int unsigned FlagXOvf   = 6;
  localparam int unsigned FlagYOvf   = 7;
  localparam int unsigned WheelSign  = 3;

  // Byte position inside a packet.
  localparam logic [1:0] IdxFlags = 2'd0;
  localparam logic [1:0] IdxX     = 2'd1;
  localparam logic [1:0] IdxY     = 2'd2;
  localparam logic [1:0] IdxWheel = 2'd3;

  // Complete packet as handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] x_low;
    logic [7:0] y_low;
    logic [3:0] wheel;
    logic       wheel_en;
  } packet_t;

  // One decoded result word.
  typedef struct packed {
    logic [2:0]             buttons;
    logic [OutPosWidth-1:0] x_position;
    logic [OutPosWidth-1:0] y_position;
    logic [OutPosWidth-1:0] z_position;
    logic                   motion_dropped;
  } result_t;

endpackage

// File: rtl/ps2md_fifo.sv
// ----------------------------------------------------------------------------
// ps2md_fifo
// Small synchronous queue, FifoDepth entries, no push while full.
// ----------------------------------------------------------------------------
module ps2md_fifo
  import ps2md_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntWidth = $clog2(FifoDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(FifoDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(FifoDepth);

  logic [Width-1:0]    mem_q [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ps2md_front.sv
// ----------------------------------------------------------------------------
// ps2md_front
// Byte framer: syncs on the flags byte and assembles complete packets.
// ----------------------------------------------------------------------------
module ps2md_front
  import ps2md_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  input  logic       wheel_en_i,
  output logic       pkt_push_o,
  output packet_t    pkt_o,
  input  logic       pkt_full_i
);

  logic [1:0] idx_q, idx_d;
  logic [7:0] flags_q, x_low_q, y_low_q;
  logic       accept, last_byte;

  assign full_o = pkt_full_i;
  assign accept = push_i & ~pkt_full_i;

  // Last byte: wheel slot in 4-byte mode, anything past X otherwise
  // (covers the length dropping mid-packet).
  assign last_byte = (idx_q == IdxWheel) || ((idx_q == IdxY) && !wheel_en_i);

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      if (idx_q == IdxFlags) begin
        if (rx_byte_i[FlagSync]) begin
          idx_d = IdxX;
        end
      end else if (last_byte) begin
        idx_d = IdxFlags;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IdxFlags;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (idx_q == IdxFlags && rx_byte_i[FlagSync]) begin
        flags_q <= rx_byte_i;
      end
      if (idx_q == IdxX) begin
        x_low_q <= rx_byte_i;
      end
      if (idx_q == IdxY) begin
        y_low_q <= rx_byte_i;
      end
    end
  end

  assign pkt_push_o = accept & (idx_q != IdxFlags) & last_byte;

  always_comb begin
    pkt_o.flags    = flags_q;
    pkt_o.x_low    = x_low_q;
    pkt_o.y_low    = (idx_q == IdxY) ? rx_byte_i : y_low_q;
    pkt_o.wheel    = rx_byte_i[3:0];
    pkt_o.wheel_en = wheel_en_i;
  end

endmodule

// File: rtl/ps2md_back.sv
// ----------------------------------------------------------------------------
// ps2md_back
// Packet executor: updates the X/Y/Z accumulators and forms result words.
// ----------------------------------------------------------------------------
module ps2md_back
  import ps2md_pkg::*;
#(
  parameter int unsigned PosWidth = PosWidthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    pkt_empty_i,
  input  packet_t pkt_i,
  output logic    pkt_pop_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  logic [PosWidth-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [PosWidth-1:0] dx, dy, dz;
  logic                dropped;
  logic [PosWidth+OutPosWidth-1:0] x_ext, y_ext, z_ext;

  assign pkt_pop_o  = ~pkt_empty_i & ~res_full_i;
  assign res_push_o = pkt_pop_o;

  assign dropped = pkt_i.flags[FlagXOvf] | pkt_i.flags[FlagYOvf];
  // 9-bit deltas: low byte plus sign flag from the first byte.
  assign dx = {{(PosWidth-8){pkt_i.flags[FlagXSign]}}, pkt_i.x_low};
  assign dy = {{(PosWidth-8){pkt_i.flags[FlagYSign]}}, pkt_i.y_low};
  assign dz = {{(PosWidth-4){pkt_i.wheel[WheelSign]}}, pkt_i.wheel};

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (!dropped) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
    end
    if (pkt_i.wheel_en) begin
      z_d = z_q + dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (pkt_pop_o) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // Zero-extend narrow accumulators, truncate wide ones.
  assign x_ext = {{OutPosWidth{1'b0}}, x_d};
  assign y_ext = {{OutPosWidth{1'b0}}, y_d};
  assign z_ext = {{OutPosWidth{1'b0}}, z_d};

  always_comb begin
    res_o.buttons        = pkt_i.flags[2:0];
    res_o.x_position     = x_ext[OutPosWidth-1:0];
    res_o.y_position     = y_ext[OutPosWidth-1:0];
    res_o.z_position     = z_ext[OutPosWidth-1:0];
    res_o.motion_dropped = dropped;
  end

endmodule

// File: rtl/ps2_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// PS/2 mouse packet decoder: frames mouse bytes into 3- or 4-byte packets and
// keeps wrapping X/Y/wheel position counters.
// ----------------------------------------------------------------------------
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-------------------------------
//  byte in   | rx_byte_i                      | push / full, taken on push&!full
//  result    | buttons_o, x/y/z_position_o,   | empty / pop, taken on pop&!empty
//            | motion_dropped_o               |
//  config    | cfg_data_i (packet length)     | cfg_valid_i / cfg_ready_o
//
//  One byte can be taken every cycle; the framer only stalls when the packet
//  queue is full. A completed packet is written into the packet queue; the
//  back end then executes it and writes its result into the result queue.
//  The back end retires one packet a cycle as long as the result queue has
//  room; a stalled reader backs up the result queue, then the packet queue,
//  and only then raises full. Reset is async, active low; length resets to 3.
//
module ps2_mouse_packet_decoder_core
  import ps2md_pkg::*;
#(
  parameter int unsigned PosWidth = PosWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte input
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             rx_byte_i,
  // results
  output logic                   empty,
  input  logic                   pop,
  output logic [2:0]             buttons_o,
  output logic signed [OutPosWidth-1:0] x_position_o,
  output logic signed [OutPosWidth-1:0] y_position_o,
  output logic signed [OutPosWidth-1:0] z_position_o,
  output logic                   motion_dropped_o,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_data_i
);

  logic [2:0] pkt_len_q;
  logic       wheel_en;

  // Packet queue between framer and executor.
  logic    pkt_push, pkt_full, pkt_pop, pkt_empty;
  packet_t pkt_in, pkt_out;

  // Result queue in front of the reader.
  logic    res_push, res_full;
  result_t res_in, res_out;

  // Config is always accepted; only a value of four turns on the wheel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_len_q <= PacketLenReset;
    end else if (cfg_valid_i) begin
      pkt_len_q <= cfg_data_i;
    end
  end

  assign wheel_en = (pkt_len_q == PacketLenWheel);

  ps2md_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .wheel_en_i (wheel_en),
    .pkt_push_o (pkt_push),
    .pkt_o      (pkt_in),
    .pkt_full_i (pkt_full)
  );

  ps2md_fifo #(
    .Width ($bits(packet_t))
  ) u_pkt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .data_i  (pkt_in),
    .full_o  (pkt_full),
    .pop_i   (pkt_pop),
    .data_o  (pkt_out),
    .empty_o (pkt_empty)
  );

  ps2md_back #(
    .PosWidth (PosWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_empty_i (pkt_empty),
    .pkt_i       (pkt_out),
    .pkt_pop_o   (pkt_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  ps2md_fifo #(
    .Width ($bits(result_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign buttons_o        = res_out.buttons;
  assign x_position_o     = res_out.x_position;
  assign y_position_o     = res_out.y_position;
  assign z_position_o     = res_out.z_position;
  assign motion_dropped_o = res_out.motion_dropped;

endmodule

// File: test/tb_ps2_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder_core
// Drives mouse bytes into the decoder and checks every report it returns.
// A behavioral decoder inside the bench tracks framing, buttons and the
// wrapping X/Y/wheel counters; each popped report is compared field by field
// with the oldest predicted one. Directed packets cover sync filtering, delta
// extremes, overflow, wheel and packet length changes mid-packet. Random
// traffic then runs under several length settings with random stalls on both
// sides, a long reader hold-off and a sender pause until drained.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder_core;
  import ps2md_pkg::*;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  rx_byte     = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [2:0]  buttons;
  logic signed [OutPosWidth-1:0] x_position;
  logic signed [OutPosWidth-1:0] y_position;
  logic signed [OutPosWidth-1:0] z_position;
  logic        motion_dropped;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data    = 3'd0;

  ps2_mouse_packet_decoder_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .buttons_o        (buttons),
    .x_position_o     (x_position),
    .y_position_o     (y_position),
    .z_position_o     (z_position),
    .motion_dropped_o (motion_dropped),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit: if the test has not finished by then, it ends as a mismatch.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model: own copy of framing state, counters and the length reg
  // --------------------------------------------------------------------------
  logic [2:0]  model_len;
  logic [1:0]  model_pos;
  logic [7:0]  model_bytes [3];
  logic [15:0] model_x;
  logic [15:0] model_y;
  logic [15:0] model_z;
  logic [2:0]  model_btn;

  result_t     pending_reports [$];
  int          mismatch_cnt = 0;

  function automatic void decode_mouse_byte(input logic [7:0] b);
    logic [2:0]  eff_len;
    logic [7:0]  flags;
    logic        dropped;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    result_t     rep;
    // anything but four means a plain three-byte packet
    eff_len = (model_len == PacketLenWheel) ? 3'd4 : 3'd3;
    if (model_pos == IdxFlags) begin
      if (!b[FlagSync]) return;  // out of sync: byte dropped
      model_bytes[0] = b;
      model_pos      = IdxX;
      return;
    end
    if ({1'b0, model_pos} + 3'd1 < eff_len) begin
      model_bytes[model_pos] = b;
      model_pos              = model_pos + 2'd1;
      return;
    end
    // last byte of the packet; a fourth byte is never stored
    if (model_pos == IdxY) model_bytes[2] = b;
    model_pos = IdxFlags;
    flags     = model_bytes[0];
    model_btn = flags[2:0];
    dropped   = flags[FlagXOvf] | flags[FlagYOvf];
    if (!dropped) begin
      dx      = {{8{flags[FlagXSign]}}, model_bytes[1]};
      dy      = {{8{flags[FlagYSign]}}, model_bytes[2]};
      model_x = model_x + dx;
      model_y = model_y - dy;
    end
    if (eff_len == 3'd4) begin
      dz      = {{12{b[WheelSign]}}, b[3:0]};
      model_z = model_z + dz;
    end
    rep.buttons        = model_btn;
    rep.x_position     = model_x;
    rep.y_position     = model_y;
    rep.z_position     = model_z;
    rep.motion_dropped = dropped;
    pending_reports.push_back(rep);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: config writes, accepted bytes and popped reports, all sampled at
  // the edge with pre-edge values
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      model_len = PacketLenReset;
      model_pos = IdxFlags;
      model_x   = '0;
      model_y   = '0;
      model_z   = '0;
      model_btn = '0;
      pending_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) model_len = cfg_data;
      if (push && !full) decode_mouse_byte(rx_byte);
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $error("report popped with none pending");
          mismatch_cnt++;
        end else begin
          want = pending_reports.pop_front();
          if (buttons !== want.buttons) begin
            $error("buttons: expected %0d, got %0d", want.buttons, buttons);
            mismatch_cnt++;
          end
          if (x_position !== want.x_position) begin
            $error("x_position: expected %0d, got %0d",
                   $signed(want.x_position), x_position);
            mismatch_cnt++;
          end
          if (y_position !== want.y_position) begin
            $error("y_position: expected %0d, got %0d",
                   $signed(want.y_position), y_position);
            mismatch_cnt++;
          end
          if (z_position !== want.z_position) begin
            $error("z_position: expected %0d, got %0d",
                   $signed(want.z_position), z_position);
            mismatch_cnt++;
          end
          if (motion_dropped !== want.motion_dropped) begin
            $error("motion_dropped: expected %0d, got %0d",
                   want.motion_dropped, motion_dropped);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reader: random pops, a steady mode, and a long hold-off on request
  // --------------------------------------------------------------------------
  bit steady        = 1'b0;  // no idling on either side
  int hold_requests = 0;

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  logic [2:0] cur_len   = PacketLenReset;
  int         frame_pos = 0;  // sender's view of packet framing

  function automatic int packet_bytes_now();
    return (cur_len == PacketLenWheel) ? 4 : 3;
  endfunction

  // One word into the byte port; push stays high on return so back-to-back
  // words never drop it within a step.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 19) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (frame_pos == 0) frame_pos = b[FlagSync] ? 1 : 0;
    else if (frame_pos + 1 < packet_bytes_now()) frame_pos++;
    else frame_pos = 0;
  endtask

  // Stop pushing, wait for every pending report plus pipeline slack.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [2:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_len = len;
  endtask

  task automatic send_packet(input logic [7:0] f, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] w);
    send_byte(f);
    send_byte(x);
    send_byte(y);
    if (packet_bytes_now() == 4) send_byte(w);
  endtask

  // Well-formed packet with random content; finishes a broken one first.
  task automatic send_random_packet();
    logic [7:0] f;
    while (frame_pos != 0) send_byte(8'($urandom()));
    f = 8'($urandom());
    f[FlagSync] = 1'b1;
    if ($urandom_range(0, 3) != 0) begin
      f[FlagXOvf] = 1'b0;
      f[FlagYOvf] = 1'b0;
    end
    send_packet(f, 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_random_traffic(input int n_bytes);
    int sent;
    int pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_random_packet();
        sent += packet_bytes_now();
      end else if (pick < 87) begin
        // noise between packets: dropped unless mid-packet
        b = 8'($urandom());
        b[FlagSync] = 1'b0;
        send_byte(b);
        sent++;
      end else begin
        send_byte(8'($urandom()));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_sync_filter();
    send_byte(8'h00);
    send_byte(8'hF7);
  endtask

  task automatic test_delta_extremes();
    send_packet(8'h3F, 8'h00, 8'h00, 8'h00);  // both signs: -256, -256
    send_packet(8'h0F, 8'hFF, 8'hFF, 8'h00);  // +255, +255
  endtask

  task automatic test_overflow();
    send_packet(8'hB8, 8'h7F, 8'h01, 8'h00);
  endtask

  task automatic test_wheel();
    write_length(PacketLenWheel);
    send_packet(8'h08, 8'h01, 8'h01, 8'h07);  // wheel +7
    send_packet(8'h49, 8'h00, 8'h80, 8'hF8);  // wheel -8, upper nibble ignored
  endtask

  task automatic test_length_change();
    // lowered with three bytes in: next byte closes the packet, no wheel
    send_byte(8'h08);
    send_byte(8'h05);
    send_byte(8'h06);
    write_length(3'd0);
    send_byte(8'h0F);
    // raised mid-packet: the packet grows a wheel byte
    write_length(3'd7);
    send_byte(8'h0A);
    send_byte(8'h01);
    write_length(PacketLenWheel);
    send_byte(8'h02);
    send_byte(8'h01);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    send_random_traffic(150);
  endtask

  task automatic test_drain_pause();
    send_random_traffic(70);
    drain_results();
    send_random_traffic(70);
  endtask

  task automatic test_random_traffic();
    write_length(PacketLenReset);
    send_random_traffic(150);
    write_length(3'd7);
    steady = 1'b1;
    send_random_traffic(120);
    steady = 1'b0;
    write_length(PacketLenWheel);
    test_backpressure();
    write_length(3'd0);
    test_drain_pause();
    write_length(3'($urandom_range(0, 7)));
    send_random_traffic(120);
    write_length(PacketLenWheel);
    send_random_traffic(120);
    write_length(3'($urandom_range(0, 7)));
    send_random_traffic(100);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sync_filter();
    test_delta_extremes();
    test_overflow();
    test_wheel();
    test_length_change();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
